@@ rtl/field_serializer_varint_fixed_assert.svh @@
// assertion macros for the rtl top level
`ifndef FIELD_SERIALIZER_VARINT_FIXED_ASSERT_SVH
`define FIELD_SERIALIZER_VARINT_FIXED_ASSERT_SVH

`ifndef ASSERT_OFF

// checked only outside reset
`define FSVF_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("fsvf assertion failed");

// checked during reset too
`define FSVF_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("fsvf assertion failed");

`else

`define FSVF_ASSERT(lbl, prop)
`define FSVF_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

@@ rtl/fsvf_pkg.sv @@
package fsvf_pkg;

	// input item
	typedef struct packed {
		logic [2:0]  func;
		logic [63:0] value;
	} fsvf_in_t;

	// result item
	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
	} fsvf_out_t;

	// format codes
	localparam logic [2:0] FUNC_FIX8  = 3'd0;
	localparam logic [2:0] FUNC_FIX16 = 3'd1;
	localparam logic [2:0] FUNC_FIX32 = 3'd2;
	localparam logic [2:0] FUNC_FIX64 = 3'd3;
	localparam logic [2:0] FUNC_VU32  = 3'd4;
	localparam logic [2:0] FUNC_VU64  = 3'd5;
	localparam logic [2:0] FUNC_ZZ32  = 3'd6;
	localparam logic [2:0] FUNC_ZZ64  = 3'd7;

	// shift unit modes
	localparam logic [1:0] MODE_LE  = 2'd0;
	localparam logic [1:0] MODE_BE  = 2'd1;
	localparam logic [1:0] MODE_VAR = 2'd2;

	localparam logic [6:0] GROUP_MASK = 7'h7F;
	localparam int unsigned GROUP_BITS = 7;
	localparam int unsigned MAX_FIX_BYTES = 8;

	// control handed to the shift unit
	typedef struct packed {
		logic [1:0] mode;
		logic [3:0] cnt;
	} fsvf_ctl_t;

endpackage

@@ rtl/fsvf_prep.sv @@
module fsvf_prep (
	input  fsvf_pkg::fsvf_in_t  field,
	input  logic                little_endian,
	output logic [63:0]         word,
	output fsvf_pkg::fsvf_ctl_t ctl
);
	import fsvf_pkg::*;

	logic [63:0] v;
	logic [31:0] z32;
	logic [63:0] z64;

	assign v   = field.value;
	assign z32 = {v[30:0], 1'b0} ^ {32{v[31]}};
	assign z64 = {v[62:0], 1'b0} ^ {64{v[63]}};

	always_comb begin
		word     = v;
		ctl.mode = MODE_VAR;
		ctl.cnt  = 4'd0;
		case (field.func)
			FUNC_FIX8: begin
				ctl.cnt = 4'd1;
				word    = little_endian ? {56'd0, v[7:0]} : {v[7:0], 56'd0};
			end
			FUNC_FIX16: begin
				ctl.cnt = 4'd2;
				word    = little_endian ? {48'd0, v[15:0]} : {v[15:0], 48'd0};
			end
			FUNC_FIX32: begin
				ctl.cnt = 4'd4;
				word    = little_endian ? {32'd0, v[31:0]} : {v[31:0], 32'd0};
			end
			FUNC_FIX64: begin
				ctl.cnt = 4'd8;
				word    = v;
			end
			FUNC_VU32: word = {32'd0, v[31:0]};
			FUNC_VU64: word = v;
			FUNC_ZZ32: word = {32'd0, z32};
			FUNC_ZZ64: word = z64;
			default:   word = v;
		endcase
		// fixed formats: byte order picks the shift direction
		if (field.func == FUNC_FIX8 || field.func == FUNC_FIX16 ||
		    field.func == FUNC_FIX32 || field.func == FUNC_FIX64) begin
			ctl.mode = little_endian ? MODE_LE : MODE_BE;
		end
	end
endmodule

@@ rtl/fsvf_step.sv @@
module fsvf_step (
	input  logic [63:0]         word,
	input  fsvf_pkg::fsvf_ctl_t ctl,
	output fsvf_pkg::fsvf_out_t res,
	output logic [63:0]         word_nxt
);
	import fsvf_pkg::*;

	logic more;

	// another group follows while bits remain above the low seven
	assign more = |word[63:GROUP_BITS];

	always_comb begin
		case (ctl.mode)
			MODE_LE: begin
				res.out_byte = word[7:0];
				res.last     = (ctl.cnt == 4'd1);
				word_nxt     = {8'd0, word[63:8]};
			end
			MODE_BE: begin
				res.out_byte = word[63:56];
				res.last     = (ctl.cnt == 4'd1);
				word_nxt     = {word[55:0], 8'd0};
			end
			default: begin
				res.out_byte = {more, word[6:0] & GROUP_MASK};
				res.last     = !more;
				word_nxt     = word >> GROUP_BITS;
			end
		endcase
	end
endmodule

@@ rtl/field_serializer_varint_fixed.sv @@
// channel  | handshake                | payload
// ---------+--------------------------+---------------------------
// field    | field_valid / field_stall | fsvf_in_t  (func, value)
// sym      | sym_valid / sym_stall     | fsvf_out_t (out_byte, last)
// cfg      | cfg_valid / cfg_ready     | cfg_data   (little_endian)
//
// one item is accepted, then a shared shift unit emits one byte per cycle
// unless stalled: 1/2/4/8 bytes for fixed formats, 1 to 10 bytes for varints
// an item is loaded, then shifted out byte by byte; the next item is taken
// once the last byte has moved into the output register
// sym_stall holds a valid output register and so freezes the shift sequencer
// reset clears the busy flag, the output valid and little_endian (big endian)
`include "field_serializer_varint_fixed_assert.svh"

module field_serializer_varint_fixed (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                field_valid,
	output logic                field_stall,
	input  fsvf_pkg::fsvf_in_t  field,
	output logic                sym_valid,
	input  logic                sym_stall,
	output fsvf_pkg::fsvf_out_t sym,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_data
);
	import fsvf_pkg::*;

	// configuration register
	logic little_endian_q;

	// sequencer state
	logic        busy_q;
	logic [63:0] word_q;
	fsvf_ctl_t   ctl_q;

	// output register
	logic      sym_valid_q;
	fsvf_out_t sym_q;

	// prepared item and shift unit results
	logic [63:0] prep_word;
	fsvf_ctl_t   prep_ctl;
	fsvf_out_t   step_res;
	logic [63:0] step_word;

	logic accept;
	logic adv;

	fsvf_prep u_prep (
		.field        (field),
		.little_endian(little_endian_q),
		.word         (prep_word),
		.ctl          (prep_ctl)
	);

	fsvf_step u_step (
		.word    (word_q),
		.ctl     (ctl_q),
		.res     (step_res),
		.word_nxt(step_word)
	);

	// configuration is to be written only while idle (the block does not enforce this), so it is always taken
	assign cfg_ready = 1'b1;

	// busy blocks the input for the whole item
	assign field_stall = busy_q;
	assign accept      = field_valid && !busy_q;

	// a byte moves when the output register is empty or being drained
	assign adv = busy_q && (!sym_valid_q || !sym_stall);

	assign sym_valid = sym_valid_q;
	assign sym       = sym_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			little_endian_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			little_endian_q <= cfg_data;
		end
	end

	// sequencer: load, then one shift unit step per emitted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept) begin
			busy_q <= 1'b1;
		end else if (adv && step_res.last) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_q <= prep_word;
			ctl_q  <= prep_ctl;
		end else if (adv) begin
			word_q    <= step_word;
			ctl_q.cnt <= ctl_q.cnt - 4'd1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sym_valid_q <= 1'b0;
		end else if (adv) begin
			sym_valid_q <= 1'b1;
		end else if (!sym_stall) begin
			sym_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sym_q <= step_res;
		end
	end

	// an accepted item keeps the sequencer busy in the next cycle
	`FSVF_ASSERT(a_accept_busy, accept |=> busy_q)
	// the last byte ends the item
	`FSVF_ASSERT(a_last_idle, (adv && step_res.last) |=> !busy_q && sym_valid_q && sym_q.last)
	// fixed formats never run past eight bytes
	`FSVF_ASSERT(a_fix_cnt, (busy_q && ctl_q.mode != MODE_VAR) |-> (ctl_q.cnt != 4'd0 && ctl_q.cnt <= 4'(MAX_FIX_BYTES)))
	// nothing is shown right out of reset
	`FSVF_ASSERT_ALWAYS(a_rst_quiet, !arst_n |=> !sym_valid && !field_stall)

endmodule

@@ sim/fsvf_checker.sv @@
`timescale 1ns / 1ps

module fsvf_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                field_valid,
	input  logic                field_stall,
	input  fsvf_pkg::fsvf_in_t  field,
	input  logic                sym_valid,
	input  logic                sym_stall,
	input  fsvf_pkg::fsvf_out_t sym,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic                cfg_data,
	output int                  error_count,
	output int                  bytes_pending
);
	import fsvf_pkg::*;

	logic      byte_order_le;
	fsvf_out_t expected_bytes[$];

	// fixed width: byte order from the register, last on the final byte
	function automatic void push_fixed(input logic [63:0] v, input int unsigned nbytes);
		int unsigned k;
		int unsigned idx;
		fsvf_out_t   b;
		for (k = 0; k < nbytes; k++) begin
			idx = byte_order_le ? k : nbytes - 1 - k;
			b.out_byte = v[8*idx +: 8];
			b.last = (k + 1 == nbytes);
			expected_bytes = {expected_bytes, b};
		end
	endfunction

	// leb128: seven bits per byte, low group first, continuation in bit 7
	function automatic void push_varint(input logic [63:0] v);
		logic [63:0] rest;
		int unsigned n;
		fsvf_out_t   b;
		rest = v;
		n = 0;
		while (rest >= 64'h80 && n < 9) begin
			b.out_byte = {1'b1, rest[6:0]};
			b.last = 1'b0;
			expected_bytes = {expected_bytes, b};
			rest = rest >> GROUP_BITS;
			n++;
		end
		b.out_byte = rest[7:0];
		b.last = 1'b1;
		expected_bytes = {expected_bytes, b};
	endfunction

	function automatic void predict_field(input fsvf_in_t f);
		case (f.func)
			FUNC_FIX8:  push_fixed({56'd0, f.value[7:0]}, 1);
			FUNC_FIX16: push_fixed({48'd0, f.value[15:0]}, 2);
			FUNC_FIX32: push_fixed({32'd0, f.value[31:0]}, 4);
			FUNC_FIX64: push_fixed(f.value, 8);
			FUNC_VU32:  push_varint({32'd0, f.value[31:0]});
			FUNC_VU64:  push_varint(f.value);
			FUNC_ZZ32:  push_varint({32'd0, {f.value[30:0], 1'b0} ^ {32{f.value[31]}}});
			FUNC_ZZ64:  push_varint({f.value[62:0], 1'b0} ^ {64{f.value[63]}});
			default:    ;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		int        new_errs;
		fsvf_out_t want;
		if (!arst_n) begin
			byte_order_le <= 1'b0;
			expected_bytes.delete();
			error_count <= 0;
			bytes_pending <= 0;
		end else begin
			new_errs = 0;
			if (cfg_valid && cfg_ready)
				byte_order_le <= cfg_data;
			if (field_valid && !field_stall)
				predict_field(field);
			if (sym_valid && !sym_stall) begin
				if (expected_bytes.size() == 0) begin
					$display("%0t: unexpected byte %02h last %0b", $time, sym.out_byte, sym.last);
					new_errs++;
				end else begin
					want = expected_bytes.pop_front();
					if (sym.out_byte !== want.out_byte) begin
						$display("%0t: out_byte expected %02h actual %02h",
							$time, want.out_byte, sym.out_byte);
						new_errs++;
					end
					if (sym.last !== want.last) begin
						$display("%0t: last expected %0b actual %0b", $time, want.last, sym.last);
						new_errs++;
					end
				end
			end
			error_count <= error_count + new_errs;
			bytes_pending <= expected_bytes.size();
		end
	end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
	import fsvf_pkg::*;

	// byte order settings of the one register
	localparam logic ORDER_BIG    = 1'b0;
	localparam logic ORDER_LITTLE = 1'b1;

	// longest quiet stretch of a correct run is a long sink stall or source gap
	localparam int WATCHDOG_LIMIT = 2000;
	// covers the load of an item plus up to ten bytes
	localparam int DRAIN_CYCLES   = 12;

	logic      clk         = 1'b0;
	logic      arst_n      = 1'b0;
	logic      field_valid = 1'b0;
	logic      field_stall;
	fsvf_in_t  field       = '0;
	logic      sym_valid;
	logic      sym_stall   = 1'b0;
	fsvf_out_t sym;
	logic      cfg_valid   = 1'b0;
	logic      cfg_ready;
	logic      cfg_data    = 1'b0;

	int error_count;
	int bytes_pending;

	// when set neither side idles
	logic steady = 1'b0;

	// sink stall pattern state
	int   sink_left = 0;
	int   sink_pick;
	logic sink_next = 1'b0;

	int idle_cycles = 0;

	always #6 clk = ~clk;

	field_serializer_varint_fixed u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.field_valid(field_valid),
		.field_stall(field_stall),
		.field      (field),
		.sym_valid  (sym_valid),
		.sym_stall  (sym_stall),
		.sym        (sym),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	fsvf_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.field_valid  (field_valid),
		.field_stall  (field_stall),
		.field        (field),
		.sym_valid    (sym_valid),
		.sym_stall    (sym_stall),
		.sym          (sym),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.error_count  (error_count),
		.bytes_pending(bytes_pending)
	);

	// sink stalls come in runs: mostly free-flowing, short stalls,
	// and now and then a long one so stalls land on every byte position
	always @(posedge clk) begin
		if (sink_left == 0) begin
			sink_pick = $urandom_range(0, 9);
			if (steady || sink_pick < 6) begin
				sink_next = 1'b0;
				sink_left = $urandom_range(1, 20);
			end else if (sink_pick < 9) begin
				sink_next = 1'b1;
				sink_left = $urandom_range(1, 3);
			end else begin
				sink_next = 1'b1;
				sink_left = $urandom_range(10, 40);
			end
		end
		sink_left = sink_left - 1;
		sym_stall <= sink_next;
	end

	// watchdog: any handshake on any channel counts as progress
	always @(posedge clk) begin
		if (!arst_n || (field_valid && !field_stall) || (sym_valid && !sym_stall)
				|| (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// source gap after an item: mostly none, some short, a few long
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (steady || r < 6)
			return 0;
		else if (r < 9)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 30);
	endfunction

	// values biased toward group and sign boundaries
	function automatic logic [63:0] pick_value();
		logic [63:0] b;
		case ($urandom_range(0, 5))
			0, 1: return {$urandom, $urandom};
			2: return 64'($urandom_range(0, 300));
			3: begin
				// around a power of two, catches byte count steps
				b = 64'd1 << $urandom_range(0, 63);
				return b - 64'd1 + 64'($urandom_range(0, 2));
			end
			4: return ~64'($urandom_range(0, 300));
			default: return {$urandom, $urandom} >> $urandom_range(0, 63);
		endcase
	endfunction

	// called at a rising edge; returns at a rising edge after the item is taken
	task automatic send_field(input logic [2:0] func, input logic [63:0] value);
		fsvf_in_t    item;
		int unsigned gap;
		item.func = func;
		item.value = value;
		field_valid <= 1'b1;
		field <= item;
		@(posedge clk);
		while (field_stall)
			@(posedge clk);
		gap = pick_gap();
		if (gap != 0) begin
			field_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// drop valid and wait until every predicted byte has come out
	task automatic settle();
		field_valid <= 1'b0;
		@(posedge clk);
		while (bytes_pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_order(input logic le);
		settle();
		cfg_data <= le;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// fixed formats, garbage above the used width, distinct bytes in most items to show order
	task automatic send_fixed_corners();
		send_field(FUNC_FIX8,  64'hFFFF_FFFF_FFFF_FFA5);
		send_field(FUNC_FIX8,  64'h0000_0000_0000_0000);
		send_field(FUNC_FIX16, 64'hDEAD_BEEF_CAFE_0102);
		send_field(FUNC_FIX32, 64'hFFFF_FFFF_0102_0304);
		send_field(FUNC_FIX64, 64'h0102_0304_0506_0708);
		send_field(FUNC_FIX64, 64'hFFFF_FFFF_FFFF_FFFF);
	endtask

	task automatic send_random(input int count);
		repeat (count)
			send_field(3'($urandom_range(0, 7)), pick_value());
	endtask

	initial begin
		// reset held from the start, then released on an edge
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset order is big endian
		send_fixed_corners();

		// varint corners: zero, one group boundary, all ones,
		// high bits ignored by the 32 bit forms, most negative zigzag values
		send_field(FUNC_VU32, 64'h0000_0000_0000_0000);
		send_field(FUNC_VU32, 64'h0000_0000_0000_007F);
		send_field(FUNC_VU32, 64'h0000_0000_0000_0080);
		send_field(FUNC_VU32, 64'hFFFF_FFFF_FFFF_FFFF);
		send_field(FUNC_VU64, 64'h0000_0000_0000_0000);
		send_field(FUNC_VU64, 64'hFFFF_FFFF_FFFF_FFFF);
		send_field(FUNC_VU64, 64'h8000_0000_0000_0000);
		send_field(FUNC_ZZ32, 64'h0000_0000_0000_0000);
		send_field(FUNC_ZZ32, 64'hFFFF_FFFF_FFFF_FFFF);
		send_field(FUNC_ZZ32, 64'h0000_0000_8000_0000);
		send_field(FUNC_ZZ32, 64'hAAAA_AAAA_7FFF_FFFF);
		send_field(FUNC_ZZ64, 64'h0000_0000_0000_0000);
		send_field(FUNC_ZZ64, 64'hFFFF_FFFF_FFFF_FFFF);
		send_field(FUNC_ZZ64, 64'h8000_0000_0000_0000);
		send_field(FUNC_ZZ64, 64'h7FFF_FFFF_FFFF_FFFF);

		// little endian: same fixed corners, then random traffic
		write_order(ORDER_LITTLE);
		send_fixed_corners();
		send_random(80);

		// back to big endian
		write_order(ORDER_BIG);
		send_random(80);

		// little endian at full rate, no idling on either side
		write_order(ORDER_LITTLE);
		steady <= 1'b1;
		send_random(90);
		steady <= 1'b0;

		settle();
		if (error_count == 0 && bytes_pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/fsvf_pkg.sv
rtl/fsvf_prep.sv
rtl/fsvf_step.sv
rtl/field_serializer_varint_fixed.sv
sim/fsvf_checker.sv
sim/tb_top.sv
